// ===== design/set_partition_generator_unit_assert.svh =====
// Assertion macros used by the top level of the set partition generator.
`ifndef SET_PARTITION_GENERATOR_UNIT_ASSERT_SVH
`define SET_PARTITION_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("set partition generator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("set partition generator: next-cycle check failed");

`endif

// ===== design/spg_pkg.sv =====
// Package with the constants and control types of the set partition generator.
package spg_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int LABEL_W      = 4;
   localparam int BOUND_W      = 5;
   localparam int COUNT_W      = 5;
   localparam int PACKED_W     = LABEL_W * MAX_ELEMENTS;

   localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(4);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cfg_write;
      logic start;
      logic step;
      logic commit;
   } spg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic slot_free;
   } spg_status_type;

endpackage

// ===== design/spg_ctrl.sv =====
// Controller state machine of the set partition generator.
module spg_ctrl
   import spg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  spg_status_type status,
   output spg_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A request has priority over a register write that arrives in the same cycle.
   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = (state_ff == ST_IDLE) && !req_valid;
   assign cmd.start     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.cfg_write = csr_ready && csr_valid;
   assign cmd.step      = (state_ff == ST_SCAN);
   assign cmd.commit    = (state_ff == ST_RESULT) && status.slot_free;

endmodule

// ===== design/spg_datapath.sv =====
// Datapath of the set partition generator: label and bound registers, scan and result.
module spg_datapath
   import spg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  spg_cmd_type         cmd,
   output spg_status_type      status,
   input  logic                req_restart,
   input  logic [COUNT_W-1:0]  csr_element_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PACKED_W-1:0] rsp_partition_labels,
   output logic [COUNT_W-1:0]  rsp_group_count,
   output logic                rsp_last_partition,
   output logic                rsp_exhausted
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LABEL_W-1:0] label_ff [MAX_ELEMENTS];
   logic [LABEL_W-1:0] label_in [MAX_ELEMENTS];
   logic [BOUND_W-1:0] bound_ff [MAX_ELEMENTS];
   logic [BOUND_W-1:0] bound_in [MAX_ELEMENTS];
   logic               finished_ff, finished_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               exh_ff, exh_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [LABEL_W-1:0] top_ff, top_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   pivot_ff, pivot_in;
   logic [LABEL_W-1:0] piv_lab_ff, piv_lab_in;
   logic [BOUND_W-1:0] piv_bnd_ff, piv_bnd_in;

   logic [PACKED_W-1:0] labels_ff, labels_in;
   logic [COUNT_W-1:0]  groups_ff, groups_in;
   logic                last_ff, last_in;
   logic                exh_out_ff, exh_out_in;

   logic [COUNT_W-1:0]  n_active;
   logic [IDX_W-1:0]    last_idx;
   logic [LABEL_W-1:0]  cur_lab;
   logic [BOUND_W-1:0]  cur_bnd;
   logic [LABEL_W-1:0]  new_lab;
   logic [BOUND_W-1:0]  new_bnd;
   logic [PACKED_W-1:0] packed_labels;

   // Clamp the element count into one through the maximum.
   always_comb begin
      if (count_ff == '0) begin
         n_active = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_ELEMENTS)) begin
         n_active = COUNT_W'(MAX_ELEMENTS);
      end else begin
         n_active = count_ff;
      end
   end

   assign last_idx = IDX_W'(n_active - COUNT_W'(1));
   assign cur_lab  = label_ff[idx_ff];
   assign cur_bnd  = bound_ff[idx_ff];
   assign new_lab  = piv_lab_ff + LABEL_W'(1);
   assign new_bnd  = piv_bnd_ff + BOUND_W'({1'b0, new_lab} == piv_bnd_ff);

   always_comb begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         packed_labels[k*LABEL_W +: LABEL_W] =
            (COUNT_W'(k) < n_active) ? label_ff[k] : '0;
      end
   end

   assign status.scan_done = (idx_ff == '0);
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in    = count_ff;
      label_in    = label_ff;
      bound_in    = bound_ff;
      finished_in = finished_ff;
      exh_in      = exh_ff;
      idx_in      = idx_ff;
      top_in      = top_ff;
      found_in    = found_ff;
      pivot_in    = pivot_ff;
      piv_lab_in  = piv_lab_ff;
      piv_bnd_in  = piv_bnd_ff;
      labels_in   = labels_ff;
      groups_in   = groups_ff;
      last_in     = last_ff;
      exh_out_in  = exh_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.cfg_write) begin
         count_in    = csr_element_count;
         finished_in = 1'b0;
         for (int k = 0; k < MAX_ELEMENTS; k++) begin
            label_in[k] = '0;
            bound_in[k] = BOUND_W'(1);
         end
      end

      if (cmd.start) begin
         if (req_restart) begin
            finished_in = 1'b0;
            for (int k = 0; k < MAX_ELEMENTS; k++) begin
               label_in[k] = '0;
               bound_in[k] = BOUND_W'(1);
            end
         end
         exh_in   = finished_ff && !req_restart;
         idx_in   = last_idx;
         top_in   = '0;
         found_in = 1'b0;
         pivot_in = '0;
      end

      // One element per cycle, from the last one down to element zero.
      if (cmd.step) begin
         if (cur_lab > top_ff) begin
            top_in = cur_lab;
         end
         if (!found_ff && (idx_ff != '0) && ({1'b0, cur_lab} < cur_bnd)) begin
            found_in   = 1'b1;
            pivot_in   = idx_ff;
            piv_lab_in = cur_lab;
            piv_bnd_in = cur_bnd;
         end
         if (idx_ff != '0) begin
            idx_in = idx_ff - IDX_W'(1);
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (exh_ff) begin
            labels_in  = '0;
            groups_in  = '0;
            last_in    = 1'b0;
            exh_out_in = 1'b1;
         end else begin
            labels_in  = packed_labels;
            groups_in  = COUNT_W'(top_ff) + COUNT_W'(1);
            last_in    = !found_ff;
            exh_out_in = 1'b0;
            if (found_ff) begin
               for (int k = 0; k < MAX_ELEMENTS; k++) begin
                  if (IDX_W'(k) == pivot_ff) begin
                     label_in[k] = new_lab;
                  end else if ((IDX_W'(k) > pivot_ff) && (COUNT_W'(k) < n_active)) begin
                     label_in[k] = '0;
                     bound_in[k] = new_bnd;
                  end
               end
            end else begin
               finished_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= RESET_COUNT;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_ELEMENTS; k++) begin
            label_ff[k] <= '0;
            bound_ff[k] <= BOUND_W'(1);
         end
      end else begin
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         label_ff     <= label_in;
         bound_ff     <= bound_in;
      end
   end

   always_ff @(posedge clock) begin
      exh_ff     <= exh_in;
      idx_ff     <= idx_in;
      top_ff     <= top_in;
      found_ff   <= found_in;
      pivot_ff   <= pivot_in;
      piv_lab_ff <= piv_lab_in;
      piv_bnd_ff <= piv_bnd_in;
      labels_ff  <= labels_in;
      groups_ff  <= groups_in;
      last_ff    <= last_in;
      exh_out_ff <= exh_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_partition_labels = labels_ff;
   assign rsp_group_count      = groups_ff;
   assign rsp_last_partition   = last_ff;
   assign rsp_exhausted        = exh_out_ff;

endmodule

// ===== design/set_partition_generator_unit.sv =====
// Top level of the set partition generator.
// The block lists every partition of N elements into non-empty groups in
// lexicographic order of restricted growth strings, one partition per request
// transfer; each request returns the current partition (zero-based labels,
// four bits per element, element 0 in the lowest nibble) and then advances
// to the next one. A request with restart set begins again at the partition
// that holds all elements in one group, and a request made after the final
// partition returns the exhausted flag with zero labels. The element count
// register (reset value 4, zero acts as 1, values above 16 act as 16) is
// written over the csr channel while the block is idle, and each write also
// reloads the first partition. Each request is accepted, then the scan
// walks the elements one per cycle from the last down to element 0 looking
// for the pivot and the largest label, and then, once any earlier result
// is taken, the result register is loaded and the labels updated. Requests
// are handled one at a time; the result register lets a finished result
// wait on a stalled consumer while the next request is already accepted.
`include "set_partition_generator_unit_assert.svh"

module set_partition_generator_unit
   import spg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_restart,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PACKED_W-1:0] rsp_partition_labels,
   output logic [COUNT_W-1:0]  rsp_group_count,
   output logic                rsp_last_partition,
   output logic                rsp_exhausted,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_element_count
);

   spg_cmd_type    cmd;
   spg_status_type status;

   // The controller sequences accept, scan and result; the datapath holds
   // all labels, bounds and the result register.
   spg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spg_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_restart          (req_restart),
      .csr_element_count    (csr_element_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_partition_labels (rsp_partition_labels),
      .rsp_group_count      (rsp_group_count),
      .rsp_last_partition   (rsp_last_partition),
      .rsp_exhausted        (rsp_exhausted)
   );

   // An accepted request keeps the input side busy for the following cycle.
   `SPG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A register write is never taken while a request is in progress.
   `SPG_ASSERT_NOW(a_csr_only_idle, clock, reset, csr_ready, !req_stall)

   // An exhausted result carries no groups and is not marked final.
   `SPG_ASSERT_NOW(a_exhausted_empty, clock, reset, rsp_valid && rsp_exhausted, (rsp_group_count == '0) && !rsp_last_partition && (rsp_partition_labels == '0))

   // A real partition always has at least one group.
   `SPG_ASSERT_NOW(a_groups_present, clock, reset, rsp_valid && !rsp_exhausted, rsp_group_count != '0)

endmodule
